[design/fwk_pkg.sv]
// Shared types and constants for the Fenwick point-add / prefix-sum unit.
package fwk_pkg;

	localparam int unsigned POS_W    = 11;
	localparam int unsigned DELTA_W  = 32;
	localparam int unsigned SUM_W    = 64;
	localparam int unsigned S_DATA_W = 48;  // position + delta, padded to whole bytes

	localparam logic CMD_ADD   = 1'b0;
	localparam logic CMD_QUERY = 1'b1;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_WALK,
		ST_DRAIN,
		ST_DONE
	} fwk_state_t;

endpackage

[design/fwk_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module fwk_ram #(
	parameter int unsigned WIDTH = 64,
	parameter int unsigned DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

[design/fenwick_point_add_prefix_sum_unit.sv]
// Fenwick tree point-add / prefix-sum unit: sequencer, node memory, shared 64-bit adder.
// An add reads and rewrites each node on its path up the tree; a query walks down its path,
// sums the node values, raises m_tvalid and takes no new input until the result is registered.
// A path visits at most log2(TREE_SIZE) + 1 nodes, so 11 at 1024; one node access per cycle.
// Ignored adds leave the tree untouched; a query at position zero gives 0 without a walk.
// Reset: asynchronous; a clearing pass then zeroes the memory, s_tready low.
module fenwick_point_add_prefix_sum_unit
	import fwk_pkg::*;
#(
	parameter int unsigned TREE_SIZE = 1024
) (
	input  logic                clk,
	input  logic                arst_n,
	// input beats
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [S_DATA_W-1:0] s_tdata,   // [10:0] position, [42:11] delta, [47:43] zero
	input  logic                s_tuser,   // [0] command (0 add, 1 query)
	// result beats
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [SUM_W-1:0]    m_tdata    // [63:0] prefix_sum
);

	// tree positions run 1..TREE_SIZE; node p lives at address p - 1
	localparam int unsigned PW = $clog2(TREE_SIZE + 1);
	localparam int unsigned AW = $clog2(TREE_SIZE);

	fwk_state_t state_q, state_d;

	logic [PW-1:0]      cur_pos_q;
	logic [AW-1:0]      clr_q;
	logic               cmd_q;
	logic [DELTA_W-1:0] delta_q;
	logic [SUM_W-1:0]   acc_q;
	logic               vld_s1;
	logic [AW-1:0]      addr_s1;
	logic               out_valid_q;
	logic [SUM_W-1:0]   out_data_q;

	// input beat fields
	logic [POS_W-1:0]   in_pos;
	logic [DELTA_W-1:0] in_delta;
	logic               in_cmd;
	logic               in_accept;
	logic               in_zero;
	logic               in_over;

	// path stepping
	logic [PW-1:0]      low_bit;
	logic [PW:0]        nxt_up;
	logic [PW-1:0]      nxt_dn;
	logic               walk_more;
	logic               clr_last;
	logic               out_free;

	// memory and shared adder
	logic               wr_en;
	logic [AW-1:0]      wr_addr;
	logic [SUM_W-1:0]   wr_data;
	logic               rd_en;
	logic [AW-1:0]      rd_addr;
	logic [SUM_W-1:0]   rd_data;
	logic [SUM_W-1:0]   sum;

	assign in_pos    = s_tdata[POS_W-1:0];
	assign in_delta  = s_tdata[POS_W +: DELTA_W];
	assign in_cmd    = s_tuser;
	assign in_accept = s_tvalid && s_tready;
	assign in_zero   = (in_pos == '0);
	assign in_over   = (32'(in_pos) > 32'(TREE_SIZE));

	// lowest set bit of the current node picks the next one up or down the path
	assign low_bit   = cur_pos_q & (~cur_pos_q + PW'(1));
	assign nxt_up    = {1'b0, cur_pos_q} + {1'b0, low_bit};
	assign nxt_dn    = cur_pos_q - low_bit;
	assign walk_more = (cmd_q == CMD_QUERY) ? (nxt_dn != '0)
	                                        : (nxt_up <= (PW+1)'(TREE_SIZE));

	assign clr_last  = (clr_q == AW'(TREE_SIZE - 1));
	assign out_free  = !out_valid_q || m_tready;

	// one adder serves both the node update and the query accumulation
	assign sum = ((cmd_q == CMD_QUERY) ? acc_q : {{(SUM_W-DELTA_W){delta_q[DELTA_W-1]}}, delta_q})
	             + rd_data;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (clr_last) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (s_tvalid) begin
					if (in_cmd == CMD_QUERY) begin
						state_d = in_zero ? ST_DONE : ST_WALK;
					end else if (!in_zero && !in_over) begin
						state_d = ST_WALK;
					end
				end
			end
			ST_WALK: begin
				if (!walk_more) state_d = ST_DRAIN;
			end
			ST_DRAIN: begin
				state_d = (cmd_q == CMD_QUERY) ? ST_DONE : ST_IDLE;
			end
			ST_DONE: begin
				if (out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// memory port and handshake controls
	always_comb begin
		s_tready = 1'b0;
		rd_en    = 1'b0;
		rd_addr  = AW'(cur_pos_q - PW'(1));
		wr_en    = 1'b0;
		wr_addr  = addr_s1;
		wr_data  = sum;
		case (state_q)
			ST_CLEAR: begin
				wr_en   = 1'b1;
				wr_addr = clr_q;
				wr_data = '0;
			end
			ST_IDLE: begin
				s_tready = 1'b1;
			end
			ST_WALK: begin
				rd_en = 1'b1;
				wr_en = vld_s1 && (cmd_q == CMD_ADD);
			end
			ST_DRAIN: begin
				wr_en = vld_s1 && (cmd_q == CMD_ADD);
			end
			ST_DONE: begin
				s_tready = 1'b0;
			end
			default: s_tready = 1'b0;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			cur_pos_q   <= '0;
			cmd_q       <= CMD_ADD;
			vld_s1      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			vld_s1  <= (state_q == ST_WALK);
			if (state_q == ST_CLEAR) clr_q <= clr_q + AW'(1);
			if (in_accept) begin
				cmd_q     <= in_cmd;
				cur_pos_q <= (in_cmd == CMD_QUERY && in_over) ? PW'(TREE_SIZE) : PW'(in_pos);
			end else if (state_q == ST_WALK && walk_more) begin
				cur_pos_q <= (cmd_q == CMD_QUERY) ? nxt_dn : nxt_up[PW-1:0];
			end
			if (state_q == ST_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_accept) begin
			delta_q <= in_delta;
			acc_q   <= '0;
		end else if (vld_s1 && cmd_q == CMD_QUERY) begin
			acc_q <= sum;
		end
		addr_s1 <= rd_addr;
		if (state_q == ST_DONE && out_free) out_data_q <= acc_q;
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

	fwk_ram #(
		.WIDTH (SUM_W),
		.DEPTH (TREE_SIZE)
	) u_nodes (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

endmodule
